// ===== hw/rtl/ams_pkg.sv =====
// shared widths, codes and sequencer states of the accumulator machine step unit
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package ams_pkg;

  localparam int unsigned STORE_WORDS = 32;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LINE_W      = $clog2(STORE_WORDS);
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned FUNC_LSB    = 13;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_EXEC  = 2'd2;

  localparam func_t OP_JMP  = 3'd0;
  localparam func_t OP_JRP  = 3'd1;
  localparam func_t OP_LDN  = 3'd2;
  localparam func_t OP_STO  = 3'd3;
  localparam func_t OP_SUB  = 3'd4;
  localparam func_t OP_SUBA = 3'd5;
  localparam func_t OP_CMP  = 3'd6;
  localparam func_t OP_STOP = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_FETCH,
    S_EXEC,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ams_in_if.sv =====
// input channel of the accumulator machine step unit: valid, ready, request fields
// depends on ams_pkg
`default_nettype none

interface ams_in_if;
  import ams_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  line_t address;
  word_t data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ams_out_if.sv =====
// result channel of the accumulator machine step unit: valid, ready, result fields
// depends on ams_pkg
`default_nettype none

interface ams_out_if;
  import ams_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_data;
  word_t program_counter;
  word_t acc_value;
  logic  halted;
  func_t executed_opcode;

  modport source (output valid, output read_data, output program_counter,
                  output acc_value, output halted, output executed_opcode, input ready);
  modport sink   (input valid, input read_data, input program_counter,
                  input acc_value, input halted, input executed_opcode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/accumulator_machine_step_unit.sv =====
// accumulator machine step unit: 32-word store, counter, accumulator and a sequencer
// depends on ams_pkg, ams_in_if and ams_out_if
//
// usage: each item on in_i writes a store word, reads one, or executes one
// instruction; every item gives exactly one result item on out_o with the
// read word, counter, accumulator, stop flag and the executed function bits.
// in_i.ready is high only while the sequencer is idle; one item is worked on
// at a time through the single-ported store and one shared 32-bit adder.
// an execute item passes through instruction fetch, operand read and execute
// with write-back, then result load; a new item is accepted only after the
// result of the last one has been loaded into the output register.
// the result sits in an output register, so a stalled receiver does not
// block the next item; only a second finished result waits for the first
// to be taken.
// reset clears the counter, accumulator, skip and stop flags and marks all
// store words invalid so that they read as zero until written; no clearing
// pass is needed and the block is ready right after reset.
`default_nettype none

module accumulator_machine_step_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ams_in_if.sink    in_i,
  ams_out_if.source out_o
);
  import ams_pkg::*;

  state_e state_q, state_d;

  word_t pc_q, pc_d;
  word_t acc_q, acc_d;
  logic  skip_q, skip_d;
  logic  stop_q, stop_d;

  // instruction fields and pending result
  func_t func_q, func_d;
  line_t line_q, line_d;
  word_t res_rd_q, res_rd_d;
  func_t res_op_q, res_op_d;

  // store with one port and registered read
  word_t                  mem_q [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_q;
  word_t                  rdata_q;
  logic                   rvld_q;
  logic                   mem_we;
  line_t                  mem_addr;
  word_t                  mem_wdata;
  word_t                  rword;

  // shared adder
  word_t alu_a, alu_b, alu_sum;
  logic  alu_inv;

  // output register
  logic  out_valid_q, out_valid_d;
  logic  out_load;
  word_t o_rd_q, o_pc_q, o_acc_q;
  logic  o_halt_q;
  func_t o_op_q;

  assign rword   = rvld_q ? rdata_q : '0;
  assign alu_sum = alu_a + (alu_inv ? ~alu_b : alu_b) + {{(WORD_W-1){1'b0}}, alu_inv};

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    skip_d    = skip_q;
    stop_d    = stop_q;
    func_d    = func_q;
    line_d    = line_q;
    res_rd_d  = res_rd_q;
    res_op_d  = res_op_q;
    mem_we    = 1'b0;
    mem_addr  = in_i.address;
    mem_wdata = in_i.data;
    alu_a     = pc_q;
    alu_b     = skip_q ? word_t'(2) : word_t'(1);
    alu_inv   = 1'b0;
    out_load  = 1'b0;
    in_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          res_rd_d = '0;
          res_op_d = OP_JMP;
          state_d  = S_DONE;
          if (in_i.kind == KIND_WRITE) begin
            mem_we = 1'b1;
          end else if (in_i.kind == KIND_READ) begin
            state_d = S_RD;
          end else if (in_i.kind == KIND_EXEC && !stop_q) begin
            // counter step, then fetch at its low bits
            pc_d     = alu_sum;
            skip_d   = 1'b0;
            mem_addr = alu_sum[LINE_W-1:0];
            state_d  = S_FETCH;
          end
        end
      end
      S_RD: begin
        res_rd_d = rword;
        state_d  = S_DONE;
      end
      S_FETCH: begin
        func_d   = rword[FUNC_LSB +: FUNC_W];
        line_d   = rword[LINE_W-1:0];
        mem_addr = rword[LINE_W-1:0];
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        mem_addr  = line_q;
        mem_wdata = acc_q;
        res_op_d  = func_q;
        state_d   = S_DONE;
        case (func_q)
          OP_JMP: pc_d = rword;
          OP_JRP: begin
            alu_a = pc_q;
            alu_b = rword;
            pc_d  = alu_sum;
          end
          OP_LDN: begin
            alu_a   = '0;
            alu_b   = rword;
            alu_inv = 1'b1;
            acc_d   = alu_sum;
          end
          OP_STO: mem_we = 1'b1;
          OP_SUB, OP_SUBA: begin
            alu_a   = acc_q;
            alu_b   = rword;
            alu_inv = 1'b1;
            acc_d   = alu_sum;
          end
          OP_CMP: begin
            if (acc_q[WORD_W-1]) begin
              skip_d = 1'b1;
            end
          end
          default: stop_d = 1'b1;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      acc_q       <= '0;
      skip_q      <= 1'b0;
      stop_q      <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      acc_q       <= acc_d;
      skip_q      <= skip_d;
      stop_q      <= stop_d;
      rvld_q      <= vld_q[mem_addr];
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    line_q   <= line_d;
    res_rd_q <= res_rd_d;
    res_op_q <= res_op_d;
    if (out_load) begin
      o_rd_q   <= res_rd_q;
      o_pc_q   <= pc_q;
      o_acc_q  <= acc_q;
      o_halt_q <= stop_q;
      o_op_q   <= res_op_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = o_rd_q;
  assign out_o.program_counter = o_pc_q;
  assign out_o.acc_value       = o_acc_q;
  assign out_o.halted          = o_halt_q;
  assign out_o.executed_opcode = o_op_q;

`ifndef NO_ASSERTIONS
  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("item accepted while another is in progress");

  // stop is sticky
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stop flag cleared");

  // skip flag is consumed by the counter step before the fetch
  a_skip_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> !skip_q)
    else $error("skip flag still set at fetch");

  // store writes only from a write item or a store instruction
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE) || (state_q == S_EXEC && func_q == OP_STO))
    else $error("unexpected store write");

  // a reported stop instruction comes with the halted flag
  a_stop_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.executed_opcode == OP_STOP |-> out_o.halted)
    else $error("stop reported without halt");
`endif

endmodule

`default_nettype wire
